@@ hw/rtl/audio_rms_zero_crossing_meter_top_assert.svh @@
// Assertion macros for the RMS and zero-crossing meter.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef AUDIO_RMS_ZERO_CROSSING_METER_TOP_ASSERT_SVH
`define AUDIO_RMS_ZERO_CROSSING_METER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ARZC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("meter check failed");

// Next-cycle implication, checked outside reset.
`define ARZC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("meter check failed");

`endif

@@ hw/rtl/arzc_pkg.sv @@
// Shared types and constants of the RMS and zero-crossing meter.
// No dependencies; used by arzc_div, arzc_sqrt and the top level.
package arzc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int MAX_BUFFER_DEF   = 4096;
    localparam int CNT_W_DEF        = $clog2(MAX_BUFFER_DEF + 1);
    localparam int SUM_W_DEF        = 2 * SAMPLE_WIDTH_DEF - 1 + CNT_W_DEF;

    localparam int RATE_W  = 18;
    localparam int RMS_W   = 16;
    localparam int CROSS_W = 12;
    localparam int PITCH_W = 18;
    localparam int LEN_W   = 13;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

    typedef struct packed {
        logic busy;
        logic done;
    } serial_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_DIV_SUM,
        ST_SQRT,
        ST_DIV_RATE,
        ST_MUL,
        ST_OUT
    } meter_state_t;

endpackage

@@ hw/rtl/arzc_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on arzc_pkg for the status struct.
module arzc_div #(
    parameter int DIVIDEND_W = arzc_pkg::SUM_W_DEF,
    parameter int DIVISOR_W  = arzc_pkg::CNT_W_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [DIVIDEND_W-1:0]       dividend,
    input  logic [DIVISOR_W-1:0]        divisor,
    output logic [DIVIDEND_W-1:0]       quotient,
    output arzc_pkg::serial_status_t    status
);
    import arzc_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  rem_ge;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign rem_ge    = rem_shift >= {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next  = rem_ge ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], rem_ge};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ hw/rtl/arzc_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on arzc_pkg for the status struct.
module arzc_sqrt #(
    parameter int ROOT_W = arzc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [2*ROOT_W-1:0]         radicand,
    output logic [ROOT_W-1:0]           root,
    output arzc_pkg::serial_status_t    status
);
    import arzc_pkg::*;

    localparam int RAD_W  = 2 * ROOT_W;
    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;

    logic [ROOT_W+3:0]   rem_shift;
    logic [ROOT_W+3:0]   trial;
    logic [ROOT_W+3:0]   rem_diff;
    logic                fits;

    assign rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign rem_diff  = rem_shift - trial;
    assign fits      = rem_shift >= trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            step_next = STEP_W'(ROOT_W);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rem_next  = fits ? rem_diff[ROOT_W+1:0] : rem_shift[ROOT_W+1:0];
            root_next = {root_reg[ROOT_W-2:0], fits};
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ hw/rtl/audio_rms_zero_crossing_meter_top.sv @@
// Per sample: the square is built by a shift-and-add loop
//   that runs once per significant bit of the sample magnitude.
// At buffer end follow a bit-serial divide, a bit-serial root, a second divide,
//   a shift-and-add pitch multiply and the output load; the result then sits in an
//   output register while the next buffer's samples are taken.
// Synchronous active-low reset clears all buffer state and sets the rate to 44100 Hz.
`include "audio_rms_zero_crossing_meter_top_assert.svh"

module audio_rms_zero_crossing_meter_top #(
    parameter int MAX_BUFFER   = arzc_pkg::MAX_BUFFER_DEF,
    parameter int SAMPLE_WIDTH = arzc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: the sample rate in hertz.
    input  logic                              cfg_wr_en,
    input  logic [arzc_pkg::RATE_W-1:0]       cfg_wr_data,
    // Sample requests.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_sample,
    input  logic                              s_last_sample,
    // Result requests, one per buffer.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [arzc_pkg::RMS_W-1:0]        m_rms_level,
    output logic [arzc_pkg::CROSS_W-1:0]      m_crossing_count,
    output logic [arzc_pkg::PITCH_W-1:0]      m_pitch_half_hz,
    output logic [arzc_pkg::LEN_W-1:0]        m_buffer_length,
    output logic                              m_overflow
);
    import arzc_pkg::*;

    // The counters must hold MAX_BUFFER itself. The sum of squares can reach
    // MAX_BUFFER * 2^(2*SAMPLE_WIDTH-2). The shared divider is wide enough for
    // both the sum and the sample rate.
    localparam int CNT_W = $clog2(MAX_BUFFER + 1);
    localparam int SUM_W = 2 * SAMPLE_WIDTH - 1 + CNT_W;
    localparam int DIV_W = (SUM_W > RATE_W) ? SUM_W : RATE_W;
    localparam int RAD_W = 2 * SAMPLE_WIDTH;

    meter_state_t                state_reg, state_next;

    logic [RATE_W-1:0]           rate_reg, rate_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0]            cross_reg, cross_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        end_reg, end_next;
    logic                        over_reg, over_next;
    logic                        m_valid_reg, m_valid_next;

    // Datapath registers; they carry no meaning until loaded.
    logic [SAMPLE_WIDTH-1:0]     mag_reg, mag_next;
    logic [SUM_W-1:0]            addend_reg, addend_next;
    logic [SAMPLE_WIDTH-1:0]     rms_reg, rms_next;
    logic [PITCH_W-1:0]          mul_q_reg, mul_q_next;
    logic [PITCH_W-1:0]          mul_a_reg, mul_a_next;
    logic [PITCH_W-1:0]          pitch_reg, pitch_next;
    logic [RMS_W-1:0]            m_rms_reg, m_rms_next;
    logic [CROSS_W-1:0]          m_cross_reg, m_cross_next;
    logic [PITCH_W-1:0]          m_pitch_reg, m_pitch_next;
    logic [LEN_W-1:0]            m_len_reg, m_len_next;
    logic                        m_over_reg, m_over_next;

    logic [SAMPLE_WIDTH-1:0]     sample_mag;
    logic                        prev_pos, prev_neg, cur_pos, cur_neg;
    logic [CNT_W-1:0]            count_inc;

    logic                        div_start;
    logic [DIV_W-1:0]            div_dividend;
    logic [DIV_W-1:0]            div_quotient;
    serial_status_t              div_sts;
    logic                        sqrt_start;
    logic [SAMPLE_WIDTH-1:0]     sqrt_root;
    serial_status_t              sqrt_sts;

    // Magnitude of the sample; the most negative code maps to 2^(SAMPLE_WIDTH-1).
    assign sample_mag = s_sample[SAMPLE_WIDTH-1] ? $unsigned(~s_sample + 1'b1)
                                                 : $unsigned(s_sample);

    // A crossing is a strict sign change. A zero on either side never counts,
    // and since the previous sample clears to zero, the first sample of a
    // buffer cannot form one.
    assign prev_pos  = !prev_reg[SAMPLE_WIDTH-1] && (prev_reg != '0);
    assign prev_neg  = prev_reg[SAMPLE_WIDTH-1];
    assign cur_pos   = !s_sample[SAMPLE_WIDTH-1] && (s_sample != '0);
    assign cur_neg   = s_sample[SAMPLE_WIDTH-1];
    assign count_inc = count_reg + 1'b1;

    // The divider first takes the sum of squares, then the sample rate, both
    // over the buffer length. The rate divide is started from the root state.
    assign div_dividend = (state_reg == ST_SQRT) ? DIV_W'(rate_reg) : DIV_W'(sum_reg);

    always_comb begin
        state_next   = state_reg;
        rate_next    = cfg_wr_en ? cfg_wr_data : rate_reg;
        sum_next     = sum_reg;
        prev_next    = prev_reg;
        cross_next   = cross_reg;
        count_next   = count_reg;
        end_next     = end_reg;
        over_next    = over_reg;
        mag_next     = mag_reg;
        addend_next  = addend_reg;
        rms_next     = rms_reg;
        mul_q_next   = mul_q_reg;
        mul_a_next   = mul_a_reg;
        pitch_next   = pitch_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rms_next   = m_rms_reg;
        m_cross_next = m_cross_reg;
        m_pitch_next = m_pitch_reg;
        m_len_next   = m_len_reg;
        m_over_next  = m_over_reg;
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        s_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if ((prev_pos && cur_neg) || (prev_neg && cur_pos)) begin
                        cross_next = cross_reg + 1'b1;
                    end
                    prev_next   = s_sample;
                    count_next  = count_inc;
                    mag_next    = sample_mag;
                    addend_next = SUM_W'(sample_mag);
                    // The buffer closes on its mark, or is cut at MAX_BUFFER.
                    end_next    = s_last_sample || (count_inc == CNT_W'(MAX_BUFFER));
                    over_next   = !s_last_sample;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                // Shift-and-add square: one magnitude bit per cycle.
                if (mag_reg != '0) begin
                    if (mag_reg[0]) begin
                        sum_next = sum_reg + addend_reg;
                    end
                    mag_next    = mag_reg >> 1;
                    addend_next = addend_reg << 1;
                end else if (end_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_SUM;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_SUM: begin
                if (div_sts.done) begin
                    sqrt_start = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sqrt_sts.done) begin
                    rms_next   = sqrt_root;
                    div_start  = 1'b1;
                    state_next = ST_DIV_RATE;
                end
            end
            ST_DIV_RATE: begin
                if (div_sts.done) begin
                    // floor(rate / N) never exceeds the rate, so it fits RATE_W bits.
                    mul_q_next = div_quotient[PITCH_W-1:0];
                    mul_a_next = PITCH_W'(cross_reg);
                    pitch_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // Only the low PITCH_W bits of the product are reported, so the
                // shifted operand and the sum are kept at that width.
                if (mul_q_reg != '0) begin
                    if (mul_q_reg[0]) begin
                        pitch_next = pitch_reg + mul_a_reg;
                    end
                    mul_q_next = mul_q_reg >> 1;
                    mul_a_next = mul_a_reg << 1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Wait until the output register is free, then hand the result
                // over and start a fresh buffer.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rms_next   = RMS_W'(rms_reg);
                    m_cross_next = CROSS_W'(cross_reg);
                    m_pitch_next = pitch_reg;
                    m_len_next   = LEN_W'(count_reg);
                    m_over_next  = over_reg;
                    sum_next     = '0;
                    prev_next    = '0;
                    cross_next   = '0;
                    count_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rate_reg    <= RATE_RESET;
            sum_reg     <= '0;
            prev_reg    <= '0;
            cross_reg   <= '0;
            count_reg   <= '0;
            end_reg     <= 1'b0;
            over_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rate_reg    <= rate_next;
            sum_reg     <= sum_next;
            prev_reg    <= prev_next;
            cross_reg   <= cross_next;
            count_reg   <= count_next;
            end_reg     <= end_next;
            over_reg    <= over_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        addend_reg  <= addend_next;
        rms_reg     <= rms_next;
        mul_q_reg   <= mul_q_next;
        mul_a_reg   <= mul_a_next;
        pitch_reg   <= pitch_next;
        m_rms_reg   <= m_rms_next;
        m_cross_reg <= m_cross_next;
        m_pitch_reg <= m_pitch_next;
        m_len_reg   <= m_len_next;
        m_over_reg  <= m_over_next;
    end

    arzc_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .quotient (div_quotient),
        .status   (div_sts)
    );

    // The mean square is below 2^(2*SAMPLE_WIDTH-1), so the low RAD_W bits
    // of the quotient carry all of it.
    arzc_sqrt #(
        .ROOT_W (SAMPLE_WIDTH)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_quotient[RAD_W-1:0]),
        .root     (sqrt_root),
        .status   (sqrt_sts)
    );

    assign m_valid          = m_valid_reg;
    assign m_rms_level      = m_rms_reg;
    assign m_crossing_count = m_cross_reg;
    assign m_pitch_half_hz  = m_pitch_reg;
    assign m_buffer_length  = m_len_reg;
    assign m_overflow       = m_over_reg;

    `ARZC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_BUFFER))
    `ARZC_ASSERT_IMP(a_cross_below_count, 1'b1, (cross_reg < count_reg) || (count_reg == '0))
    `ARZC_ASSERT_IMP(a_div_done_state, div_sts.done,
                     (state_reg == ST_DIV_SUM) || (state_reg == ST_DIV_RATE))
    `ARZC_ASSERT_IMP(a_units_exclusive, div_sts.busy, !sqrt_sts.busy)
    `ARZC_ASSERT_NXT(a_out_clears, (state_reg == ST_OUT) && (state_next == ST_IDLE),
                     (count_reg == '0) && (sum_reg == '0) && m_valid_reg)

endmodule
